// ===== rtl/rgblit_pkg.sv =====
// Shared types and constants for the run-length glyph blitter.
// Holds the stream payload layout, command codes and the queued command type.
// No dependencies.
package rgblit_pkg;

  // Input stream payload: tuser carries func, tdata the remaining fields.
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam int POS_X_LSB   = 0;
  localparam int POS_Y_LSB   = 12;
  localparam int GW_LSB      = 24;
  localparam int GH_LSB      = 32;
  localparam int XOFF_LSB    = 40;
  localparam int YOFF_LSB    = 48;
  localparam int SKIPT_LSB   = 56;
  localparam int SKIPB_LSB   = 67;
  localparam int RUNB_LSB    = 75;

  localparam int PIX_ADDR_W  = 20;
  localparam int ADDR_LSB    = 0;
  localparam int COLOR_LSB   = 20;
  localparam int ADV_LSB     = 28;

  // Item kinds carried on in_tuser.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_RUN   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_PALETTE      = 1'b1;

  localparam logic [11:0] SCREEN_WIDTH_RST = 12'd640;
  localparam logic signed [10:0] TOP_CLIP_MAX = 11'sd1023;
  localparam int SKIP_SHIFT = 3;
  localparam logic [2:0] COLOR_MASK = 3'h7;

  // Bits of quotient produced by the restoring divider.
  localparam int DIV_STEPS = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic               kind;
    logic [12:0]        y_sum;   // pos_y + y_offset
    logic [12:0]        x_sum;   // pos_x + x_offset
    logic [8:0]         adv;     // x_offset + glyph_width
    logic [7:0]         cw;      // cell width, zero taken as one
    logic [7:0]         gh;
    logic signed [10:0] top;
    logic [7:0]         bot;
    logic [4:0]         skip;
    logic [2:0]         color;
  } cmd_t;

endpackage

// ===== rtl/rgblit_front.sv =====
// Front end of the glyph blitter: input stream handshake and item decode.
// Unpacks the payload into a queued command. Depends on rgblit_pkg.
module rgblit_front import rgblit_pkg::*; (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_push_cmd
);

  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [7:0]  gw;
  logic [7:0]  xoff;
  logic [7:0]  yoff;
  logic [7:0]  run_byte;

  assign pos_x    = in_tdata[POS_X_LSB +: 12];
  assign pos_y    = in_tdata[POS_Y_LSB +: 12];
  assign gw       = in_tdata[GW_LSB +: 8];
  assign xoff     = in_tdata[XOFF_LSB +: 8];
  assign yoff     = in_tdata[YOFF_LSB +: 8];
  assign run_byte = in_tdata[RUNB_LSB +: 8];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_push_cmd.kind  = in_tuser;
    q_push_cmd.y_sum = 13'(pos_y) + 13'(yoff);
    q_push_cmd.x_sum = 13'(pos_x) + 13'(xoff);
    q_push_cmd.adv   = 9'(xoff) + 9'(gw);
    q_push_cmd.cw    = (gw == 8'd0) ? 8'd1 : gw;
    q_push_cmd.gh    = in_tdata[GH_LSB +: 8];
    q_push_cmd.top   = $signed(in_tdata[SKIPT_LSB +: 11]);
    q_push_cmd.bot   = in_tdata[SKIPB_LSB +: 8];
    q_push_cmd.skip  = run_byte[7:SKIP_SHIFT];
    q_push_cmd.color = run_byte[2:0] & COLOR_MASK;
  end

endmodule

// ===== rtl/rgblit_queue.sv =====
// Short command queue between the blitter front end and back end.
// Lets either side stall on its own. Depends on rgblit_pkg.
module rgblit_queue import rgblit_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && head_valid)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop && head_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && head_valid) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/rgblit_back.sv =====
// Back end of the glyph blitter: glyph state, line stepping and pixel output.
// Holds the configuration registers, an iterative divider and the output stage.
// Depends on rgblit_pkg.
module rgblit_back import rgblit_pkg::*; #(
  parameter int ADDR_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int SUM_W = (ADDR_BITS > 26) ? ADDR_BITS : 26;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WRAP  = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_PIX   = 3'd6;

  logic [2:0]           state_r,  state_nxt;
  cmd_t                 cmd_r,    cmd_nxt;
  logic [24:0]          prod_r,   prod_nxt;
  logic [8:0]           j_r,      j_nxt;
  logic [8:0]           quo_r,    quo_nxt;
  logic [8:0]           rem_r,    rem_nxt;
  logic [3:0]           cnt_r,    cnt_nxt;
  logic [ADDR_BITS-1:0] la_r,     la_nxt;
  logic [7:0]           col_r,    col_nxt;
  logic [7:0]           lines_r,  lines_nxt;
  logic signed [10:0]   top_r,    top_nxt;
  logic [7:0]           bot_r,    bot_nxt;
  logic [7:0]           cw_r,     cw_nxt;
  logic                 act_r,    act_nxt;
  logic [11:0]          sw_r;
  logic [63:0]          pal_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 out_user_r;
  logic                 out_last_r;

  logic                 out_free;
  logic [12:0]          mul_a;
  logic [24:0]          mul_p;
  logic [SUM_W-1:0]     start_sum;
  logic [SUM_W-1:0]     step_sum;
  logic [SUM_W-1:0]     pix_sum;
  logic [31:0]          pix_addr32;
  logic [9:0]           trial;
  logic signed [11:0]   tc;
  logic signed [9:0]    lines_left;
  logic                 emit;
  logic                 e_write;
  logic [PIX_ADDR_W-1:0] e_addr;
  logic [7:0]           e_color;
  logic                 e_done;
  logic [8:0]           e_adv;

  assign out_free = !out_valid_r || out_tready;

  // One multiplier: start line address, then line steps on a wrap.
  assign mul_a = (state_r == S_IDLE) ? q_cmd.y_sum : 13'(quo_r);
  assign mul_p = mul_a * sw_r;

  assign start_sum  = SUM_W'(prod_r) + SUM_W'(cmd_r.x_sum);
  assign step_sum   = SUM_W'(la_r) + SUM_W'(prod_r);
  assign pix_sum    = SUM_W'(la_r) + SUM_W'(rem_r[7:0]);
  assign pix_addr32 = 32'(pix_sum[ADDR_BITS-1:0]);
  assign trial      = {1'b0, rem_r[7:0], quo_r[8]};
  assign tc         = 12'(top_r) + $signed({3'b000, quo_r});
  assign lines_left = $signed({2'b00, lines_r}) - $signed({1'b0, quo_r});

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    prod_nxt  = prod_r;
    j_nxt     = j_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    la_nxt    = la_r;
    col_nxt   = col_r;
    lines_nxt = lines_r;
    top_nxt   = top_r;
    bot_nxt   = bot_r;
    cw_nxt    = cw_r;
    act_nxt   = act_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    e_write   = 1'b0;
    e_addr    = '0;
    e_color   = '0;
    e_done    = 1'b0;
    e_adv     = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.kind == KIND_START) begin
            prod_nxt  = mul_p;
            state_nxt = S_START;
          end else if (!act_r) begin
            // run byte with no glyph open: answer done and drop it
            emit   = 1'b1;
            e_done = 1'b1;
          end else begin
            j_nxt     = 9'(col_r) + 9'(q_cmd.skip);
            state_nxt = S_RUN;
          end
        end
      end
      S_START: begin
        la_nxt    = start_sum[ADDR_BITS-1:0];
        col_nxt   = '0;
        lines_nxt = cmd_r.gh;
        top_nxt   = cmd_r.top;
        bot_nxt   = cmd_r.bot;
        cw_nxt    = cmd_r.cw;
        act_nxt   = (cmd_r.gh > cmd_r.bot);
        emit      = 1'b1;
        e_done    = !(cmd_r.gh > cmd_r.bot);
        e_adv     = cmd_r.adv;
        state_nxt = S_IDLE;
      end
      S_RUN: begin
        if (j_r < {1'b0, cw_r}) begin
          rem_nxt   = j_r;
          state_nxt = S_PIX;
        end else begin
          quo_nxt   = j_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (trial >= {2'b00, cw_r}) begin
          rem_nxt = 9'(trial - {2'b00, cw_r});
          quo_nxt = {quo_r[7:0], 1'b1};
        end else begin
          rem_nxt = trial[8:0];
          quo_nxt = {quo_r[7:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'(DIV_STEPS - 1)) begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        top_nxt = (tc > 12'sd1023) ? TOP_CLIP_MAX : tc[10:0];
        if (lines_left <= $signed({2'b00, bot_r})) begin
          act_nxt   = 1'b0;
          lines_nxt = '0;
          emit      = 1'b1;
          e_done    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          lines_nxt = lines_left[7:0];
          prod_nxt  = mul_p;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        la_nxt    = step_sum[ADDR_BITS-1:0];
        state_nxt = S_PIX;
      end
      S_PIX: begin
        col_nxt = rem_r[7:0] + 8'd1;
        emit    = 1'b1;
        if (!top_r[10]) begin
          e_write = 1'b1;
          e_addr  = pix_addr32[PIX_ADDR_W-1:0];
          e_color = pal_r[{cmd_r.color, 3'b000} +: 8];
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    prod_r <= prod_nxt;
    j_r    <= j_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    if (emit) begin
      // pixel_addr, pixel_color, advance_width from the low bit up
      out_data_r <= OUT_DATA_W'({e_adv, e_color, e_addr});
      out_user_r <= e_write;
      out_last_r <= e_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      la_r        <= '0;
      col_r       <= '0;
      lines_r     <= '0;
      top_r       <= '0;
      bot_r       <= '0;
      cw_r        <= 8'd1;
      act_r       <= 1'b0;
      sw_r        <= SCREEN_WIDTH_RST;
      pal_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      la_r    <= la_nxt;
      col_r   <= col_nxt;
      lines_r <= lines_nxt;
      top_r   <= top_nxt;
      bot_r   <= bot_nxt;
      cw_r    <= cw_nxt;
      act_r   <= act_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_SCREEN_WIDTH: sw_r  <= cfg_wdata[11:0];
          REG_PALETTE:      pal_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_act_width: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (cw_r != 8'd0))
    else $error("open glyph with zero cell width");

  a_act_lines: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (lines_r > bot_r))
    else $error("open glyph already past bottom clip");

  a_write_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r) |-> !out_last_r)
    else $error("pixel store flagged as glyph end");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < {1'b0, cw_r}))
    else $error("divider remainder out of range");
`endif

endmodule

// ===== rtl/rle_glyph_blitter_unit.sv =====
// Run-length glyph blitter: top level.
// Joins front end, command queue and back end. Depends on rgblit_pkg.
//
// Usage:
//   in_*  : one transaction per item. in_tuser = 0 starts a glyph with its
//           metrics and clip counts, in_tuser = 1 carries one run byte.
//   out_* : exactly one result transaction per input item, in order.
//           out_tuser marks a pixel store, out_tlast marks glyph end.
//   cfg_* : screen width (index 0) and palette word (index 1); write only
//           while no item is in flight.
// Items: the back end handles a start item in its start state and a run
// byte in its run and pixel states; a run byte that wraps to a later line
// also passes the one-bit-per-cycle divider that splits the column into
// lines and remainder. The back end takes one item at a time; a two-entry
// queue keeps the input side taking items meanwhile.
// Reset: all glyph state clears, no glyph is open, screen width returns to
// 640 and the palette to zero.
// Stall: while out_tready is low the result is held; the back end then stops
// taking commands and, once the queue fills, in_tready drops.
module rle_glyph_blitter_unit import rgblit_pkg::*; #(
  parameter int ADDR_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x, pos_y, glyph_width, glyph_height, x_offset, y_offset,
  // skip_top, skip_bottom, run_byte, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pixel_addr, pixel_color, advance_width, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // pixel_write
  output logic                  out_tuser,
  // glyph_done
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  rgblit_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_cmd (q_push_cmd)
  );

  rgblit_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  rgblit_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
